// File: sv/esm_pkg.sv
// ----------------------------------------------------------------------------
// esm_pkg
// Shared types, constants and the fixed tables of the Euler rotation, scale
// and translate matrix block.
// ----------------------------------------------------------------------------
package esm_pkg;

    localparam int TRIG_TABLE_BITS_DEF = 14;
    localparam int QUEUE_DEPTH         = 2;
    localparam int NUM_COLS            = 3;
    localparam int MAG_W               = 15;   // sine magnitude, 0 .. 16384
    localparam int IN_TDATA_W          = 192;
    localparam int OUT_TDATA_W         = 128;

    localparam logic [63:0] TWO_PI_Q60 = 64'h6487_ED51_10B4_611A;
    localparam logic [31:0] ONE_Q16    = 32'h0001_0000;
    localparam logic [1:0]  ROW_LAST   = 2'd3;

    // 2^74 / d + 1 for the series divisors d = 2n(2n+1), entry n-1; a 64-bit
    // dividend times this, shifted down by 74, is exactly floor(dividend / d)
    localparam int RECIP_SHIFT = 74;
    localparam logic [13:0][79:0] SERIES_RECIP = {
        (80'd1 << 74) / 80'd812 + 80'd1,
        (80'd1 << 74) / 80'd702 + 80'd1,
        (80'd1 << 74) / 80'd600 + 80'd1,
        (80'd1 << 74) / 80'd506 + 80'd1,
        (80'd1 << 74) / 80'd420 + 80'd1,
        (80'd1 << 74) / 80'd342 + 80'd1,
        (80'd1 << 74) / 80'd272 + 80'd1,
        (80'd1 << 74) / 80'd210 + 80'd1,
        (80'd1 << 74) / 80'd156 + 80'd1,
        (80'd1 << 74) / 80'd110 + 80'd1,
        (80'd1 << 74) / 80'd72  + 80'd1,
        (80'd1 << 74) / 80'd42  + 80'd1,
        (80'd1 << 74) / 80'd20  + 80'd1,
        (80'd1 << 74) / 80'd6   + 80'd1
    };

    // cmd codes
    localparam logic CMD_SPACE = 1'b0;
    localparam logic CMD_BODY  = 1'b1;

    typedef enum logic [2:0] {
        TRG_CX,
        TRG_SX,
        TRG_CY,
        TRG_SY,
        TRG_CZ,
        TRG_SZ
    } t_trig;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_X,
        FR_Y,
        FR_Z
    } t_front_state;

    typedef struct packed {
        logic               cmd;
        logic [15:0]        turn_x;
        logic [15:0]        turn_y;
        logic [15:0]        turn_z;
        logic signed [15:0] scale_x;
        logic signed [15:0] scale_y;
        logic signed [15:0] scale_z;
        logic signed [31:0] shift_x;
        logic signed [31:0] shift_y;
        logic signed [31:0] shift_z;
    } t_item;

    // one classified item: trig values looked up, ready for the lanes
    typedef struct packed {
        logic               cmd;
        logic signed [15:0] cx;
        logic signed [15:0] sx;
        logic signed [15:0] cy;
        logic signed [15:0] sy;
        logic signed [15:0] cz;
        logic signed [15:0] sz;
        logic [2:0][15:0]   scale;
        logic [2:0][31:0]   shift;
    } t_job;

    // element = A (+/-) B, A = a1*a2 or a1 alone, B = (b1*b2)*b3
    typedef struct packed {
        t_trig a1;
        logic  a1_neg;
        t_trig a2;
        logic  a_raw;
        logic  b_use;
        logic  b_sub;
        t_trig b1;
        logic  b1_neg;
        t_trig b2;
        t_trig b3;
    } t_elem_ctrl;

    // Quarter-wave sine entry j, Q1.14, for a table of 2^tbits steps.
    // Evaluated at elaboration only: Taylor series in Q60, rounded.
    function automatic logic [MAG_W-1:0] quarter_sin(input int unsigned tbits,
                                                     input int unsigned j);
        logic [63:0]  step;
        logic [63:0]  x;
        logic [63:0]  x2;
        logic [63:0]  term;
        logic [63:0]  sum;
        logic [127:0] prod;
        logic [159:0] wide;
        step = (TWO_PI_Q60 + (64'd1 << (tbits - 1))) >> tbits;
        x    = 64'(j) * step;
        prod = 128'(x) * 128'(x);
        x2   = prod[123:60];
        term = x;
        sum  = x;
        for (int n = 1; n <= 14; n++) begin
            prod = 128'(term) * 128'(x2);
            wide = 160'(prod[123:60]) * 160'(SERIES_RECIP[n-1]);
            term = wide[RECIP_SHIFT+63:RECIP_SHIFT];
            if (n[0]) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        sum = sum + (64'd1 << 45);
        return MAG_W'(sum >> 46);
    endfunction

    function automatic t_elem_ctrl pair(input t_trig a1, input logic a1_neg,
                                        input t_trig a2);
        t_elem_ctrl c;
        c        = '0;
        c.a1     = a1;
        c.a1_neg = a1_neg;
        c.a2     = a2;
        return c;
    endfunction

    function automatic t_elem_ctrl raw(input t_trig a1);
        t_elem_ctrl c;
        c       = '0;
        c.a1    = a1;
        c.a_raw = 1'b1;
        return c;
    endfunction

    function automatic t_elem_ctrl trip(input t_elem_ctrl base, input logic sub,
                                        input t_trig b1, input logic b1_neg,
                                        input t_trig b2, input t_trig b3);
        t_elem_ctrl c;
        c        = base;
        c.b_use  = 1'b1;
        c.b_sub  = sub;
        c.b1     = b1;
        c.b1_neg = b1_neg;
        c.b2     = b2;
        c.b3     = b3;
        return c;
    endfunction

    // Rotation term recipe per convention, row and column.
    function automatic t_elem_ctrl elem_ctrl(input logic cmd, input logic [1:0] row,
                                             input logic [1:0] col);
        t_elem_ctrl c;
        c = '0;
        case ({cmd, row, col})
            {CMD_SPACE, 2'd0, 2'd0}: c = pair(TRG_CZ, 1'b0, TRG_CY);
            {CMD_SPACE, 2'd1, 2'd0}: c = trip(pair(TRG_SZ, 1'b0, TRG_CX), 1'b0,
                                              TRG_CZ, 1'b0, TRG_SY, TRG_SX);
            {CMD_SPACE, 2'd2, 2'd0}: c = trip(pair(TRG_SZ, 1'b0, TRG_SX), 1'b1,
                                              TRG_CZ, 1'b0, TRG_SY, TRG_CX);
            {CMD_SPACE, 2'd0, 2'd1}: c = pair(TRG_SZ, 1'b1, TRG_CY);
            {CMD_SPACE, 2'd1, 2'd1}: c = trip(pair(TRG_CZ, 1'b0, TRG_CX), 1'b0,
                                              TRG_SZ, 1'b1, TRG_SY, TRG_SX);
            {CMD_SPACE, 2'd2, 2'd1}: c = trip(pair(TRG_CZ, 1'b0, TRG_SX), 1'b0,
                                              TRG_SZ, 1'b0, TRG_SY, TRG_CX);
            {CMD_SPACE, 2'd0, 2'd2}: c = raw(TRG_SY);
            {CMD_SPACE, 2'd1, 2'd2}: c = pair(TRG_CY, 1'b1, TRG_SX);
            {CMD_SPACE, 2'd2, 2'd2}: c = pair(TRG_CY, 1'b0, TRG_CX);
            {CMD_BODY,  2'd0, 2'd0}: c = trip(pair(TRG_CZ, 1'b0, TRG_CY), 1'b1,
                                              TRG_SZ, 1'b0, TRG_SY, TRG_SX);
            {CMD_BODY,  2'd1, 2'd0}: c = trip(pair(TRG_SZ, 1'b0, TRG_CY), 1'b0,
                                              TRG_CZ, 1'b0, TRG_SY, TRG_SX);
            {CMD_BODY,  2'd2, 2'd0}: c = pair(TRG_CX, 1'b1, TRG_SY);
            {CMD_BODY,  2'd0, 2'd1}: c = pair(TRG_SZ, 1'b1, TRG_CX);
            {CMD_BODY,  2'd1, 2'd1}: c = pair(TRG_CZ, 1'b0, TRG_CX);
            {CMD_BODY,  2'd2, 2'd1}: c = raw(TRG_SX);
            {CMD_BODY,  2'd0, 2'd2}: c = trip(pair(TRG_CZ, 1'b0, TRG_SY), 1'b0,
                                              TRG_SZ, 1'b0, TRG_SX, TRG_CY);
            {CMD_BODY,  2'd1, 2'd2}: c = trip(pair(TRG_SZ, 1'b0, TRG_SY), 1'b1,
                                              TRG_CZ, 1'b0, TRG_SX, TRG_CY);
            {CMD_BODY,  2'd2, 2'd2}: c = pair(TRG_CY, 1'b0, TRG_CX);
            default:                 c = '0;
        endcase
        return c;
    endfunction

endpackage

// File: sv/euler_scale_translate_matrix.sv
// ----------------------------------------------------------------------------
// euler_scale_translate_matrix
// Euler rotation, per-axis scale and translation as one 4x4 Q16.16 matrix.
// ----------------------------------------------------------------------------
// Each input word (three angles, three Q8.8 scales, three Q16.16 shifts and a
// convention bit in tuser) yields four output words, rows 0 to 3, with the
// row index in tuser and tlast on row 3. The back end issues one matrix row
// per cycle into three column lanes while the output is not stalled. The
// front end does one sine/cosine table read per axis and runs ahead into a
// two-entry job queue, so it can take a new word before the back end is
// through with the last one. The first row passes the table reads, the
// queue and the back end registers. Angles use the low TRIG_TABLE_BITS bits.
// No state is kept between words and no configuration exists.
// ----------------------------------------------------------------------------
module euler_scale_translate_matrix #(
    parameter int TRIG_TABLE_BITS = esm_pkg::TRIG_TABLE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // turn_x, turn_y, turn_z, scale_x, scale_y, scale_z, shift_x, shift_y, shift_z
    input  logic [esm_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // cmd
    input  logic                            i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // elem0, elem1, elem2, elem3
    output logic [esm_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    // row
    output logic [1:0]                      o_m_axis_tuser,
    output logic                            o_m_axis_tlast
);

    esm_pkg::t_item w_item;
    esm_pkg::t_job  w_push_job;
    esm_pkg::t_job  w_head_job;
    logic           w_push;
    logic           w_full;
    logic           w_head_valid;
    logic           w_pop;

    always_comb begin
        w_item.cmd     = i_s_axis_tuser;
        w_item.turn_x  = i_s_axis_tdata[15:0];
        w_item.turn_y  = i_s_axis_tdata[31:16];
        w_item.turn_z  = i_s_axis_tdata[47:32];
        w_item.scale_x = i_s_axis_tdata[63:48];
        w_item.scale_y = i_s_axis_tdata[79:64];
        w_item.scale_z = i_s_axis_tdata[95:80];
        w_item.shift_x = i_s_axis_tdata[127:96];
        w_item.shift_y = i_s_axis_tdata[159:128];
        w_item.shift_z = i_s_axis_tdata[191:160];
    end

    esm_front #(
        .TABLE_BITS (TRIG_TABLE_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_item  (w_item),
        .o_push  (w_push),
        .o_job   (w_push_job),
        .i_full  (w_full)
    );

    esm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_job),
        .o_full  (w_full),
        .o_valid (w_head_valid),
        .o_data  (w_head_job),
        .i_pop   (w_pop)
    );

    esm_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_job_valid     (w_head_valid),
        .i_job           (w_head_job),
        .o_pop           (w_pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule

// File: sv/esm_trig_rom.sv
// ----------------------------------------------------------------------------
// esm_trig_rom
// Quarter-wave sine table with two folded lookups (sine and cosine of one
// angle) and a registered read.
// ----------------------------------------------------------------------------
module esm_trig_rom #(
    parameter int TABLE_BITS = esm_pkg::TRIG_TABLE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [TABLE_BITS-1:0] i_angle,
    output logic signed [15:0]    o_sin,
    output logic signed [15:0]    o_cos
);

    localparam int QTR   = 1 << (TABLE_BITS - 2);
    localparam int IDX_W = TABLE_BITS - 1;

    logic [esm_pkg::MAG_W-1:0] w_tbl [QTR+1];
    logic [TABLE_BITS-1:0]     w_cos_angle;
    logic [IDX_W-1:0]          w_sin_idx;
    logic [IDX_W-1:0]          w_cos_idx;
    logic [esm_pkg::MAG_W-1:0] r_sin_mag;
    logic [esm_pkg::MAG_W-1:0] r_cos_mag;
    logic                      r_sin_neg;
    logic                      r_cos_neg;

    for (genvar j = 0; j <= QTR; j++) begin : g_tbl
        assign w_tbl[j] = esm_pkg::quarter_sin(TABLE_BITS, j);
    end

    // odd quadrants read the table backwards
    function automatic logic [IDX_W-1:0] fold(input logic [TABLE_BITS-1:0] k);
        logic [IDX_W-1:0] r;
        r = IDX_W'(k[TABLE_BITS-3:0]);
        return k[TABLE_BITS-2] ? (IDX_W'(QTR) - r) : r;
    endfunction

    assign w_cos_angle = i_angle + TABLE_BITS'(QTR);
    assign w_sin_idx   = fold(i_angle);
    assign w_cos_idx   = fold(w_cos_angle);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sin_mag <= w_tbl[w_sin_idx];
            r_cos_mag <= w_tbl[w_cos_idx];
            r_sin_neg <= i_angle[TABLE_BITS-1];
            r_cos_neg <= w_cos_angle[TABLE_BITS-1];
        end
    end

    assign o_sin = r_sin_neg ? -$signed({1'b0, r_sin_mag}) : $signed({1'b0, r_sin_mag});
    assign o_cos = r_cos_neg ? -$signed({1'b0, r_cos_mag}) : $signed({1'b0, r_cos_mag});

endmodule

// File: sv/esm_front.sv
// ----------------------------------------------------------------------------
// esm_front
// Takes input words, looks up sine and cosine of the three angles (one axis
// per cycle) and pushes a complete job into the queue.
// ----------------------------------------------------------------------------
module esm_front #(
    parameter int TABLE_BITS = esm_pkg::TRIG_TABLE_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  esm_pkg::t_item i_item,
    output logic          o_push,
    output esm_pkg::t_job o_job,
    input  logic          i_full
);

    esm_pkg::t_front_state r_state;
    esm_pkg::t_front_state n_state;
    esm_pkg::t_item        r_item;
    logic signed [15:0]    r_cx;
    logic signed [15:0]    r_sx;
    logic signed [15:0]    r_cy;
    logic signed [15:0]    r_sy;
    logic                  w_accept;
    logic                  w_rd_en;
    logic [TABLE_BITS-1:0] w_angle;
    logic signed [15:0]    w_sin;
    logic signed [15:0]    w_cos;

    esm_trig_rom #(
        .TABLE_BITS (TABLE_BITS)
    ) u_rom (
        .i_clk   (i_clk),
        .i_en    (w_rd_en),
        .i_angle (w_angle),
        .o_sin   (w_sin),
        .o_cos   (w_cos)
    );

    // state names which axis the ROM output currently holds
    always_comb begin
        n_state = r_state;
        o_push  = 1'b0;
        w_rd_en = 1'b0;
        w_angle = i_item.turn_x[TABLE_BITS-1:0];
        unique case (r_state)
            esm_pkg::FR_IDLE: begin
                o_ready = 1'b1;
            end
            esm_pkg::FR_X: begin
                o_ready = 1'b0;
                w_rd_en = 1'b1;
                w_angle = r_item.turn_y[TABLE_BITS-1:0];
                n_state = esm_pkg::FR_Y;
            end
            esm_pkg::FR_Y: begin
                o_ready = 1'b0;
                w_rd_en = 1'b1;
                w_angle = r_item.turn_z[TABLE_BITS-1:0];
                n_state = esm_pkg::FR_Z;
            end
            esm_pkg::FR_Z: begin
                o_push  = !i_full;
                o_ready = !i_full;
                if (!i_full) begin
                    n_state = esm_pkg::FR_IDLE;
                end
            end
            default: begin
                o_ready = 1'b0;
                n_state = esm_pkg::FR_IDLE;
            end
        endcase
        w_accept = i_valid && o_ready;
        if (w_accept) begin
            w_rd_en = 1'b1;
            n_state = esm_pkg::FR_X;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= esm_pkg::FR_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_item;
        end
        if (r_state == esm_pkg::FR_X) begin
            r_cx <= w_cos;
            r_sx <= w_sin;
        end
        if (r_state == esm_pkg::FR_Y) begin
            r_cy <= w_cos;
            r_sy <= w_sin;
        end
    end

    // z comes straight off the ROM, which holds while the queue is full
    always_comb begin
        o_job.cmd   = r_item.cmd;
        o_job.cx    = r_cx;
        o_job.sx    = r_sx;
        o_job.cy    = r_cy;
        o_job.sy    = r_sy;
        o_job.cz    = w_cos;
        o_job.sz    = w_sin;
        o_job.scale = {r_item.scale_z, r_item.scale_y, r_item.scale_x};
        o_job.shift = {r_item.shift_z, r_item.shift_y, r_item.shift_x};
    end

endmodule

// File: sv/esm_queue.sv
// ----------------------------------------------------------------------------
// esm_queue
// Short job queue between the lookup front end and the matrix back end.
// ----------------------------------------------------------------------------
module esm_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  esm_pkg::t_job i_data,
    output logic          o_full,
    output logic          o_valid,
    output esm_pkg::t_job o_data,
    input  logic          i_pop
);

    localparam int DEPTH = esm_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    esm_pkg::t_job    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// File: sv/esm_back.sv
// ----------------------------------------------------------------------------
// esm_back
// Issues one matrix row per cycle, while the output is not stalled, from the
// queued job into three column lanes: pair product, triple product, sum,
// scale. Last stage is the output register.
// ----------------------------------------------------------------------------
module esm_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_job_valid,
    input  esm_pkg::t_job                       i_job,
    output logic                                o_pop,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [esm_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata,
    output logic [1:0]                          o_m_axis_tuser,
    output logic                                o_m_axis_tlast
);

    localparam int NC = esm_pkg::NUM_COLS;

    typedef struct packed {
        logic [1:0]       row;
        logic [2:0][15:0] sc;
        logic [31:0]      elem3;
    } t_meta;

    logic [1:0]          r_row;
    logic                w_issue;
    logic                w_rdy1;
    logic                w_rdy2;
    logic                w_rdy3;
    logic                w_rdy4;
    logic                r_v1;
    logic                r_v2;
    logic                r_v3;
    logic                r_v4;
    t_meta               w_meta0;
    t_meta               r1_meta;
    t_meta               r2_meta;
    t_meta               r3_meta;
    logic [1:0]          r4_row;
    logic [31:0]         r4_elem3;
    esm_pkg::t_elem_ctrl w_ctl [NC];
    logic signed [16:0]  w_a1  [NC];
    logic signed [16:0]  w_b1  [NC];
    logic signed [16:0]  n1_a  [NC];
    logic signed [16:0]  n1_b  [NC];
    logic signed [16:0]  r1_a  [NC];
    logic signed [16:0]  r1_b  [NC];
    logic signed [15:0]  r1_b3 [NC];
    logic                r1_buse [NC];
    logic                r1_bsub [NC];
    logic signed [16:0]  r2_a  [NC];
    logic signed [16:0]  r2_b  [NC];
    logic                r2_bsub [NC];
    logic signed [17:0]  r3_t  [NC];
    logic signed [33:0]  w_p4  [NC];
    logic [31:0]         r4_e  [NC];

    function automatic logic signed [15:0] pick(input esm_pkg::t_job j,
                                                input esm_pkg::t_trig s);
        logic signed [15:0] v;
        unique case (s)
            esm_pkg::TRG_CX: v = j.cx;
            esm_pkg::TRG_SX: v = j.sx;
            esm_pkg::TRG_CY: v = j.cy;
            esm_pkg::TRG_SY: v = j.sy;
            esm_pkg::TRG_CZ: v = j.cz;
            esm_pkg::TRG_SZ: v = j.sz;
            default:         v = '0;
        endcase
        return v;
    endfunction

    // Q1.14 product, floor shift
    function automatic logic signed [16:0] mq(input logic signed [16:0] a,
                                              input logic signed [15:0] b);
        logic signed [32:0] p;
        p = a * b;
        return 17'(p >>> 14);
    endfunction

    assign w_rdy4  = !r_v4 || i_m_axis_tready;
    assign w_rdy3  = !r_v3 || w_rdy4;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign w_issue = i_job_valid && w_rdy1;
    assign o_pop   = w_issue && (r_row == esm_pkg::ROW_LAST);

    always_comb begin
        w_meta0.row = r_row;
        w_meta0.sc  = i_job.scale;
        case (r_row)
            2'd0:    w_meta0.elem3 = i_job.shift[0];
            2'd1:    w_meta0.elem3 = i_job.shift[1];
            2'd2:    w_meta0.elem3 = i_job.shift[2];
            default: w_meta0.elem3 = esm_pkg::ONE_Q16;
        endcase
    end

    always_comb begin
        for (int c = 0; c < NC; c++) begin
            w_ctl[c] = esm_pkg::elem_ctrl(i_job.cmd, r_row, 2'(c));
            w_a1[c]  = 17'(pick(i_job, w_ctl[c].a1));
            if (w_ctl[c].a1_neg) begin
                w_a1[c] = -w_a1[c];
            end
            w_b1[c] = 17'(pick(i_job, w_ctl[c].b1));
            if (w_ctl[c].b1_neg) begin
                w_b1[c] = -w_b1[c];
            end
            n1_a[c] = w_ctl[c].a_raw ? w_a1[c] : mq(w_a1[c], pick(i_job, w_ctl[c].a2));
            n1_b[c] = mq(w_b1[c], pick(i_job, w_ctl[c].b2));
            w_p4[c] = $signed(r3_meta.sc[c]) * r3_t[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
            r_v4  <= 1'b0;
        end else begin
            if (w_issue) begin
                r_row <= r_row + 2'd1;
            end
            if (w_rdy1) begin
                r_v1 <= w_issue;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
            if (w_rdy4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r1_meta <= w_meta0;
            for (int c = 0; c < NC; c++) begin
                r1_a[c]    <= n1_a[c];
                r1_b[c]    <= n1_b[c];
                r1_b3[c]   <= pick(i_job, w_ctl[c].b3);
                r1_buse[c] <= w_ctl[c].b_use;
                r1_bsub[c] <= w_ctl[c].b_sub;
            end
        end
        if (w_rdy2) begin
            r2_meta <= r1_meta;
            for (int c = 0; c < NC; c++) begin
                r2_a[c]    <= r1_a[c];
                r2_b[c]    <= r1_buse[c] ? mq(r1_b[c], r1_b3[c]) : '0;
                r2_bsub[c] <= r1_bsub[c];
            end
        end
        if (w_rdy3) begin
            r3_meta <= r2_meta;
            for (int c = 0; c < NC; c++) begin
                r3_t[c] <= r2_bsub[c] ? (18'(r2_a[c]) - 18'(r2_b[c]))
                                      : (18'(r2_a[c]) + 18'(r2_b[c]));
            end
        end
        if (w_rdy4) begin
            r4_row   <= r3_meta.row;
            r4_elem3 <= r3_meta.elem3;
            for (int c = 0; c < NC; c++) begin
                // Q8.8 x Q1.14 -> Q16.16; the bottom row's three lane elements are zero
                r4_e[c] <= (r3_meta.row == esm_pkg::ROW_LAST) ? '0 : 32'(w_p4[c] >>> 6);
            end
        end
    end

    assign o_m_axis_tvalid = r_v4;
    assign o_m_axis_tdata  = {r4_elem3, r4_e[2], r4_e[1], r4_e[0]};
    assign o_m_axis_tuser  = r4_row;
    assign o_m_axis_tlast  = (r4_row == esm_pkg::ROW_LAST);

endmodule

// File: sv/esm_checker.sv
// ----------------------------------------------------------------------------
// esm_checker
// Port-level checks on the matrix output stream, bound to the top level.
// ----------------------------------------------------------------------------
module esm_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_m_valid,
    input logic                            i_m_ready,
    input logic [esm_pkg::OUT_TDATA_W-1:0] i_m_data,
    input logic [1:0]                      i_m_user,
    input logic                            i_m_last
);

    logic [1:0] r_exp_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_row <= '0;
        end else if (i_m_valid && i_m_ready) begin
            r_exp_row <= r_exp_row + 2'd1;
        end
    end

    a_row_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_valid |-> (i_m_user == r_exp_row))
        else $error("matrix rows out of order");

    a_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_valid |-> (i_m_last == (i_m_user == esm_pkg::ROW_LAST)))
        else $error("tlast does not mark the bottom row");

    a_bottom_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_valid && i_m_last) |->
            ((i_m_data[95:0] == '0) && (i_m_data[127:96] == esm_pkg::ONE_Q16)))
        else $error("bottom row is not 0, 0, 0, 1.0");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_valid && !i_m_ready) |=>
            (i_m_valid && $stable(i_m_data) && $stable(i_m_user)))
        else $error("stalled output word changed");

endmodule

bind euler_scale_translate_matrix esm_checker u_esm_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_m_valid (o_m_axis_tvalid),
    .i_m_ready (i_m_axis_tready),
    .i_m_data  (o_m_axis_tdata),
    .i_m_user  (o_m_axis_tuser),
    .i_m_last  (o_m_axis_tlast)
);
